@@ src/cbd_pkg.sv @@
package cbd_pkg;

    // Width of the chunk size counter; sizes needing more bits are errors.
    localparam int SIZE_BITS = 32;

    localparam int BYTE_W  = 8;
    localparam int EVENT_W = 2;

    // Result kinds carried on the result channel's tuser.
    localparam logic [EVENT_W-1:0] EV_PAYLOAD  = 2'd0;
    localparam logic [EVENT_W-1:0] EV_COMPLETE = 2'd1;
    localparam logic [EVENT_W-1:0] EV_ERROR    = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] body_byte;
        logic              restart;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  payload_byte;
        logic [EVENT_W-1:0] event_res;
    } result_t;

    // Bit 4 flags a hex digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

@@ src/cbd_in_reg.sv @@
module cbd_in_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // body_byte
    input  logic                 s_tuser,   // restart
    input  logic                 advance,
    output logic                 item_valid,
    output cbd_pkg::item_t       item
);
    import cbd_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // The register can take a new beat when empty or when its item moves on.
    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.body_byte <= s_tdata;
            item_reg.restart   <= s_tuser;
        end
    end

endmodule

@@ src/cbd_parser.sv @@
module cbd_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  cbd_pkg::item_t       item,
    output logic                 res_valid,
    output cbd_pkg::result_t     res
);
    import cbd_pkg::*;

    localparam logic [2:0] PH_LEAD   = 3'd0;
    localparam logic [2:0] PH_DIGITS = 3'd1;
    localparam logic [2:0] PH_EXT    = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_TAIL   = 3'd4;
    localparam logic [2:0] PH_TAILCR = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;
    localparam logic [2:0] PH_ERROR  = 3'd7;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;

    logic [2:0]           phase_reg, phase_next, phase_cur;
    logic [SIZE_BITS-1:0] count_reg, count_next, count_cur;
    logic                 lz_reg, lz_next, lz_cur;
    logic [7:0]           c;
    logic [4:0]           hex;
    logic                 is_blank;
    logic                 size_done;

    assign c        = item.body_byte;
    assign hex      = hex_digit(c);
    assign is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
                      (c == CH_FF) || (c == CH_CR);

    always_comb begin
        // A restart beat sees the decoder as just out of reset.
        phase_cur = item.restart ? PH_LEAD : phase_reg;
        count_cur = item.restart ? '0 : count_reg;
        lz_cur    = item.restart ? 1'b0 : lz_reg;

        phase_next       = phase_cur;
        count_next       = count_cur;
        lz_next          = lz_cur;
        size_done        = 1'b0;
        res_valid        = 1'b0;
        res.payload_byte = '0;
        res.event_res    = EV_PAYLOAD;

        unique case (phase_cur)
            PH_LEAD: begin
                if (c == CH_LF) begin
                    size_done = 1'b1;
                end else if (is_blank) begin
                    phase_next = PH_LEAD;
                end else if (c == CH_ZERO) begin
                    count_next = '0;
                    lz_next    = 1'b1;
                    phase_next = PH_DIGITS;
                end else if (hex[4]) begin
                    count_next = SIZE_BITS'(hex[3:0]);
                    phase_next = PH_DIGITS;
                end else begin
                    phase_next = PH_EXT;
                end
            end
            PH_DIGITS: begin
                lz_next = 1'b0;
                if (lz_cur && (c == CH_X_LO || c == CH_X_UP)) begin
                    phase_next = PH_DIGITS;
                end else if (hex[4]) begin
                    if (count_cur[SIZE_BITS-1 -: 4] != 4'd0) begin
                        phase_next    = PH_ERROR;
                        res_valid     = 1'b1;
                        res.event_res = EV_ERROR;
                    end else begin
                        count_next = {count_cur[SIZE_BITS-5:0], hex[3:0]};
                    end
                end else if (c == CH_LF) begin
                    size_done = 1'b1;
                end else begin
                    phase_next = PH_EXT;
                end
            end
            PH_EXT: begin
                if (c == CH_LF) begin
                    size_done = 1'b1;
                end
            end
            PH_DATA: begin
                count_next       = count_cur - SIZE_BITS'(1);
                res_valid        = 1'b1;
                res.payload_byte = c;
                if (count_cur == SIZE_BITS'(1)) begin
                    phase_next = PH_TAIL;
                end
            end
            PH_TAIL: begin
                if (c == CH_CR) begin
                    phase_next = PH_TAILCR;
                end else if (c == CH_LF) begin
                    phase_next = PH_LEAD;
                end else begin
                    phase_next    = PH_ERROR;
                    res_valid     = 1'b1;
                    res.event_res = EV_ERROR;
                end
            end
            PH_TAILCR: begin
                if (c == CH_LF) begin
                    phase_next = PH_LEAD;
                end else begin
                    phase_next    = PH_ERROR;
                    res_valid     = 1'b1;
                    res.event_res = EV_ERROR;
                end
            end
            default: begin
                phase_next = phase_cur;
            end
        endcase

        // End of a size line: a zero size finishes the body, any other size opens the payload.
        if (size_done) begin
            lz_next = 1'b0;
            if (count_cur == '0) begin
                phase_next    = PH_DONE;
                res_valid     = 1'b1;
                res.event_res = EV_COMPLETE;
            end else begin
                phase_next = PH_DATA;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEAD;
            count_reg <= '0;
            lz_reg    <= 1'b0;
        end else if (fire) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            lz_reg    <= lz_next;
        end
    end

endmodule

@@ src/cbd_out_reg.sv @@
module cbd_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  logic                 res_valid,
    input  cbd_pkg::result_t     res,
    output logic                 free,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // payload_byte
    output logic [1:0]           m_tuser    // event_res
);
    import cbd_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // Free when empty or when the held beat leaves this cycle.
    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.payload_byte;
    assign m_tuser  = res_reg.event_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= fire && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res_valid) begin
            res_reg <= res;
        end
    end

endmodule

@@ src/http_chunked_body_decode.sv @@
// Chunked transfer body decoder.
// The slave channel carries the raw message body one byte per beat; tuser
// set on a beat clears the decoder before that byte is parsed. The master
// channel carries decoded payload bytes (tuser = 0), one completion beat
// (tuser = 1) when a zero-size chunk line ends, or one error beat (tuser = 2)
// for a size overflow or a chunk not closed by CRLF or LF. Framing bytes
// produce no beat at all. After completion or an error, bytes are swallowed
// until a beat with restart set arrives.
// Each accepted byte is held in an input register, is parsed by the state
// logic and its result lands in the output register. One byte per cycle
// is sustained while the receiver keeps tready high; the rate is set by the
// single parse step between the two registers, which also updates the phase
// and the chunk size counter.
// Reset (aresetn low, sampled on aclk) empties both registers and puts the
// parser at the start of a size line. When the receiver holds tready low,
// the output register keeps its beat, the input register keeps the next byte,
// and s_tready drops until the output register frees up.
module http_chunked_body_decode (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // body_byte
    input  logic        s_tuser,    // restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // payload_byte
    output logic [1:0]  m_tuser     // event_res
);
    import cbd_pkg::*;

    item_t   item;
    result_t res;
    logic    item_valid;
    logic    out_free;
    logic    res_valid;
    logic    advance;

    // The held byte is parsed when the output register can take its result.
    assign advance = item_valid && out_free;

    cbd_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    cbd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    cbd_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (advance),
        .res_valid (res_valid),
        .res       (res),
        .free      (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

@@ tb/tb_http_chunked_body_decode.sv @@
`timescale 1ns / 100ps

module tb_http_chunked_body_decode;
    import cbd_pkg::*;

    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 10;   // idle time after the last owed result has drained
    localparam int WATCHDOG_LIMIT = 2000; // idle cycles; well above the longest gap or stall
    localparam int MAX_REPORTS    = 10;

    // Characters that steer the size line and the chunk tail.
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_VT      = 8'h0B;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_LOWER_X = 8'h78;

    // Parser phases of the decoder as the checker tracks them.
    typedef enum logic [2:0] {
        ST_SIZE_LEAD,
        ST_SIZE_DIGITS,
        ST_SIZE_EXT,
        ST_PAYLOAD,
        ST_CHUNK_END,
        ST_CHUNK_END_LF,
        ST_FINISHED,
        ST_FAILED
    } parse_phase_e;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // body_byte
    logic       s_tuser;    // restart
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // payload_byte
    logic [1:0] m_tuser;    // event_res

    // Shadow copy of the decoder state, advanced once per accepted input beat.
    parse_phase_e         dec_phase     = ST_SIZE_LEAD;
    logic [SIZE_BITS-1:0] dec_remaining = '0;
    logic                 dec_lead_zero = 1'b0;

    // Results still owed by the decoder, oldest first.
    result_t pending_results[$];

    int mismatches  = 0;
    int beats_live  = 0;  // beats the decoder actually parses
    int idle_cycles = 0;
    int ready_hold  = 0;
    bit restart_next = 1'b0;
    bit steady_flow  = 1'b0;

    http_chunked_body_decode i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Expected behavior.
    // ------------------------------------------------------------------

    function automatic bit is_size_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
    endfunction

    // Value of a hex character, or -1 for anything else.
    function automatic int hex_weight(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
        return -1;
    endfunction

    // An LF closes the size line: a zero size ends the body, anything else
    // opens the payload.
    task automatic close_size_line(output bit got, output result_t res);
        got = 1'b0;
        res = '0;
        dec_lead_zero = 1'b0;
        if (dec_remaining == '0) begin
            dec_phase     = ST_FINISHED;
            got           = 1'b1;
            res.event_res = EV_COMPLETE;
        end else begin
            dec_phase = ST_PAYLOAD;
        end
    endtask

    // Advance the shadow parser by one body byte; got says whether the
    // decoder owes a result beat for it.
    task automatic predict_beat(input logic [7:0] c, input logic rst,
                                output bit got, output result_t res);
        int w;
        got = 1'b0;
        res = '0;
        if (rst) begin
            dec_phase     = ST_SIZE_LEAD;
            dec_remaining = '0;
            dec_lead_zero = 1'b0;
        end
        w = hex_weight(c);
        case (dec_phase)
            ST_SIZE_LEAD: begin
                if (c == CH_LF) begin
                    close_size_line(got, res);
                end else if (is_size_blank(c)) begin
                    // Leading whitespace is skipped.
                end else if (c == CH_ZERO) begin
                    dec_remaining = '0;
                    dec_lead_zero = 1'b1;
                    dec_phase     = ST_SIZE_DIGITS;
                end else if (w >= 0) begin
                    dec_remaining = SIZE_BITS'(w);
                    dec_phase     = ST_SIZE_DIGITS;
                end else begin
                    dec_phase = ST_SIZE_EXT;
                end
            end
            ST_SIZE_DIGITS: begin
                if (dec_lead_zero && (c == CH_LOWER_X || c == CH_UPPER_X)) begin
                    dec_lead_zero = 1'b0;
                end else begin
                    dec_lead_zero = 1'b0;
                    if (w >= 0) begin
                        // One more digit would push a set bit past the counter.
                        if (dec_remaining[SIZE_BITS-1 -: 4] != 4'd0) begin
                            dec_phase     = ST_FAILED;
                            got           = 1'b1;
                            res.event_res = EV_ERROR;
                        end else begin
                            dec_remaining = {dec_remaining[SIZE_BITS-5:0], 4'(w)};
                        end
                    end else if (c == CH_LF) begin
                        close_size_line(got, res);
                    end else begin
                        dec_phase = ST_SIZE_EXT;
                    end
                end
            end
            ST_SIZE_EXT: begin
                if (c == CH_LF) begin
                    close_size_line(got, res);
                end
            end
            ST_PAYLOAD: begin
                dec_remaining    = dec_remaining - 1'b1;
                if (dec_remaining == '0) begin
                    dec_phase = ST_CHUNK_END;
                end
                got              = 1'b1;
                res.payload_byte = c;
                res.event_res    = EV_PAYLOAD;
            end
            ST_CHUNK_END: begin
                if (c == CH_CR) begin
                    dec_phase = ST_CHUNK_END_LF;
                end else if (c == CH_LF) begin
                    dec_phase = ST_SIZE_LEAD;
                end else begin
                    dec_phase     = ST_FAILED;
                    got           = 1'b1;
                    res.event_res = EV_ERROR;
                end
            end
            ST_CHUNK_END_LF: begin
                if (c == CH_LF) begin
                    dec_phase = ST_SIZE_LEAD;
                end else begin
                    dec_phase     = ST_FAILED;
                    got           = 1'b1;
                    res.event_res = EV_ERROR;
                end
            end
            default: begin
                // Finished or failed: the byte is swallowed until restart.
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Beat driving on the input side.
    // ------------------------------------------------------------------

    // A fair coin.
    function automatic bit coin();
        return 1'($urandom_range(0, 1));
    endfunction

    // Most gaps are zero or short, a few are long; none in steady mode.
    function automatic int pick_gap();
        int r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one beat, wait for the handshake and record what it should cause.
    // tvalid stays high on return so that back-to-back beats need no toggle.
    task automatic send_beat(input logic [7:0] c, input logic rst);
        int      gap;
        bit      got;
        result_t res;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= rst;
        do @(posedge aclk); while (!s_tready);
        if (rst || (dec_phase != ST_FINISHED && dec_phase != ST_FAILED)) begin
            beats_live++;
        end
        predict_beat(c, rst, got, res);
        if (got) begin
            pending_results.push_back(res);
        end
    endtask

    // Body bytes carry restart only on the first beat of a new body.
    task automatic body_byte(input logic [7:0] c);
        send_beat(c, restart_next);
        restart_next = 1'b0;
    endtask

    task automatic send_text(input string s);
        foreach (s[i]) body_byte(s[i]);
    endtask

    task automatic send_line_break(input bit with_cr);
        if (with_cr) body_byte(CH_CR);
        body_byte(CH_LF);
    endtask

    // Hold the input side idle until every owed result has come out.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Random body building blocks.
    // ------------------------------------------------------------------

    function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
        if (n < 4'd10) return 8'h30 + n;
        return 8'((upper ? 8'h41 : 8'h61) + n - 10);
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 4))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_VT;
            3:       return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_ext_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
        return c;
    endfunction

    // A size line for a nonzero size, in one of its many spellings.
    task automatic size_line(input int size);
        int nd;
        int form;
        repeat ($urandom_range(0, 2)) body_byte(pick_blank());
        form = $urandom_range(0, 9);
        if (form == 0) begin
            body_byte(CH_ZERO);
            body_byte(coin() ? CH_UPPER_X : CH_LOWER_X);
        end else if (form == 1) begin
            repeat ($urandom_range(1, 2)) body_byte(CH_ZERO);
        end
        nd = 1;
        while ((size >> (4 * nd)) != 0) nd++;
        for (int k = nd - 1; k >= 0; k--) begin
            body_byte(hex_char(4'(size >> (4 * k)), coin()));
        end
        if ($urandom_range(0, 4) == 0) begin
            body_byte(CH_SEMI);
            repeat ($urandom_range(0, 4)) body_byte(pick_ext_byte());
        end
        send_line_break(coin());
    endtask

    // Nine significant digits: the last one cannot fit the size counter.
    task automatic overflow_line();
        body_byte(hex_char(4'($urandom_range(1, 15)), coin()));
        repeat (8) body_byte(hex_char(4'($urandom_range(0, 15)), coin()));
    endtask

    // The line that ends a body, in one of five forms that read as size zero.
    task automatic last_line();
        case ($urandom_range(0, 4))
            0: begin
                send_text("0");
                send_line_break(coin());
            end
            1: begin
                repeat ($urandom_range(0, 2)) body_byte(pick_blank());
                send_line_break(coin());
            end
            2: begin
                send_text(coin() ? "0X" : "0x");
                send_line_break(coin());
            end
            3: begin
                send_text("00;");
                repeat ($urandom_range(0, 3)) body_byte(pick_ext_byte());
                send_line_break(1'b1);
            end
            default: begin
                send_text(coin() ? "-1" : "+a");
                send_line_break(coin());
            end
        endcase
    endtask

    // One body: mostly well-formed chunks with random payload, sometimes
    // noise, an overflowing size, a broken tail or a body cut short by the
    // restart of the next one.
    task automatic random_body();
        int n_chunks;
        int size;
        int r;
        restart_next = 1'b1;
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 16)) body_byte(8'($urandom_range(0, 255)));
            return;
        end
        n_chunks = $urandom_range(0, 4);
        for (int i = 0; i < n_chunks; i++) begin
            if ($urandom_range(0, 99) < 3) begin
                overflow_line();
                return;
            end
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48)
                                               : $urandom_range(1, 12);
            size_line(size);
            if ($urandom_range(0, 99) < 3) begin
                repeat ($urandom_range(0, size - 1)) body_byte(8'($urandom_range(0, 255)));
                return;
            end
            repeat (size) body_byte(8'($urandom_range(0, 255)));
            r = $urandom_range(0, 99);
            if (r < 5) begin
                body_byte(8'($urandom_range(0, 255)));
            end else begin
                send_line_break(r < 50);
            end
        end
        last_line();
        repeat ($urandom_range(0, 2)) body_byte(8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // The first body straight out of reset, without restart: payload bytes
    // at both extremes, a CRLF tail, then a terminating line and a byte
    // that must be swallowed.
    task automatic test_first_body_after_reset();
        restart_next = 1'b0;
        send_text("2");
        body_byte(CH_LF);
        body_byte(8'h00);
        body_byte(8'hFF);
        send_line_break(1'b1);
        send_text("0");
        body_byte(CH_LF);
        send_text("Z");
    endtask

    // Size line spellings: blanks, a bare "0x" prefix, a sign character,
    // an uppercase prefix with an extension, a bare LF tail and an empty
    // terminating line.
    task automatic test_size_line_forms();
        restart_next = 1'b1;
        body_byte(CH_SPACE);
        send_text("0x");
        body_byte(CH_LF);

        restart_next = 1'b1;
        send_text("+3");
        body_byte(CH_LF);

        restart_next = 1'b1;
        body_byte(CH_CR);
        body_byte(CH_VT);
        body_byte(CH_FF);
        body_byte(CH_TAB);
        send_text("0X1;");
        send_line_break(1'b1);
        body_byte(8'h5A);
        body_byte(CH_LF);
        body_byte(CH_LF);
    endtask

    // The largest size that fits is taken; one more digit is an error.
    task automatic test_size_overflow();
        restart_next = 1'b1;
        send_text("fFFFFFFF;");
        restart_next = 1'b1;
        send_text("fFFFFFFF0");
        send_text("1");
    endtask

    // A chunk tail that is neither CRLF nor LF.
    task automatic test_bad_chunk_end();
        restart_next = 1'b1;
        send_text("1");
        body_byte(CH_LF);
        send_text("AB");

        restart_next = 1'b1;
        send_text("1");
        body_byte(CH_LF);
        send_text("A");
        body_byte(CH_CR);
        body_byte(CH_CR);
    endtask

    // Random bodies with gaps and stalls on both sides; halfway through,
    // the sender waits until the output has caught up.
    task automatic test_random_traffic(input int beat_goal);
        int first;
        first = beats_live;
        while (beats_live - first < beat_goal / 2) random_body();
        wait_results_drained();
        while (beats_live - first < beat_goal) random_body();
    endtask

    // Random bodies at full rate, with the receiver ready once any running stall ends.
    task automatic test_back_to_back_traffic(input int beat_goal);
        int first;
        first = beats_live;
        steady_flow = 1'b1;
        while (beats_live - first < beat_goal) random_body();
        steady_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side: receiver stalls and checking.
    // ------------------------------------------------------------------

    // Bursts of ready of random length, broken by mostly short stalls.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (ready_hold > 0) begin
                ready_hold--;
            end else if (steady_flow || !m_tready) begin
                m_tready   <= 1'b1;
                ready_hold = steady_flow ? 0 : $urandom_range(1, 20);
            end else begin
                m_tready   <= 1'b0;
                ready_hold = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 2)
                                                          : $urandom_range(7, 29);
            end
        end
    end

    task automatic report_mismatch(input string what, input int expected, input int actual);
        if (mismatches < MAX_REPORTS) begin
            $display("mismatch %s: expected %0d, got %0d", what, expected, actual);
        end
        mismatches++;
    endtask

    // Every output beat is held against the oldest owed result.
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat, event_res", -1, m_tuser);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.event_res) begin
                    report_mismatch("event_res", want.event_res, m_tuser);
                end
                if (m_tdata !== want.payload_byte) begin
                    report_mismatch("payload_byte", want.payload_byte, m_tdata);
                end
            end
        end
    end

    // Ends a hung run: too many cycles in a row without a beat on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_http_chunked_body_decode: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence.
    // ------------------------------------------------------------------

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tuser  <= 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        test_first_body_after_reset();
        test_size_line_forms();
        test_size_overflow();
        test_bad_chunk_end();
        test_random_traffic(200);
        test_back_to_back_traffic(120);

        // Let the pipeline empty before judging the run.
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb_http_chunked_body_decode: clean");
        end else begin
            $display("tb_http_chunked_body_decode: errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/cbd_pkg.sv
src/cbd_in_reg.sv
src/cbd_parser.sv
src/cbd_out_reg.sv
src/http_chunked_body_decode.sv
tb/tb_http_chunked_body_decode.sv
